[rtl/core/spcu_pkg.sv]
// shared types and constants for the sorted prefix-sum counter
// no dependencies; imported by the cell, the encoder and the top level
`default_nettype none

package spcu_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int ELEM_W   = 20;
    localparam int QSUM_W   = 26;
    localparam int LEN_W    = 7;
    localparam int IN_TD_W  = 48;
    localparam int OUT_TD_W = 8;

    // control handed from one cell to its right-hand neighbour
    typedef struct packed {
        logic valid;  // cell holds a stored value
        logic shift;  // cell moves right (or takes the new value) on a load
    } t_link;

endpackage

`default_nettype wire

[rtl/core/smallest_prefix_count_under_limit.sv]
// top level of the sorted prefix-sum counter: handshake, command decode and the cell chain
// depends on spcu_pkg, spcu_cell and spcu_count_enc
`default_nettype none

// Keeps up to CAPACITY positive values in ascending order in a chain of cells,
// each cell holding one value, the running sum up to it and a valid bit. A load
// transaction inserts its value: every cell at or right of the insertion point
// takes its left neighbour's value (or the new value) and sets its sum to the
// left neighbour's old sum plus the new value, so only one adder per cell is
// needed. Zero values and loads into a full chain are dropped. A clear
// transaction empties the chain. Loads and clears give no result and are taken
// back to back, one per cycle, while no query is in flight. A query transaction
// returns how many of the smallest values sum to no more than the limit: first
// every cell compares its sum with the limit and registers a hit flag, then the
// thermometer of hits is turned into a count and registered on the output.
// tready stays low after a query is taken until its count has moved into the
// output register, which waits while that register still holds a result not
// yet taken. subseq_len is the count modulo 128.
module smallest_prefix_count_under_limit
    import spcu_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 20
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [IN_TD_W-1:0]  s_axis_tdata,   // element_value[19:0], query_sum[45:20], zero pad
    input  wire logic [CMD_W-1:0]    s_axis_tuser,   // cmd[1:0]
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_TD_W-1:0]      m_axis_tdata    // subseq_len[6:0], zero pad
);

    // widths that follow from the parameters
    localparam int SUM_W  = VALUE_BITS + $clog2(CAPACITY);
    localparam int CMP_W  = (SUM_W > QSUM_W) ? SUM_W : QSUM_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int VIN_W  = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;

    // input transaction fields
    logic [ELEM_W-1:0]     w_elem;
    logic [QSUM_W-1:0]     w_qsum;
    logic [CMD_W-1:0]      w_cmd;
    logic [VALUE_BITS-1:0] w_value;
    logic [CMP_W-1:0]      w_limit;

    logic w_in_fire;
    logic w_out_fire;
    logic w_full;
    logic w_load;
    logic w_clear;
    logic w_query;
    logic w_advance;

    // query in flight: hit flags captured, count not yet on the output
    logic r_q1;
    logic n_q1;
    logic r_out_valid;
    logic n_out_valid;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] w_len;

    // chain wiring; position zero is the seed to the left of the first cell
    t_link                 w_link  [0:CAPACITY];
    logic [VALUE_BITS-1:0] w_vals  [0:CAPACITY];
    logic [SUM_W-1:0]      w_sums  [0:CAPACITY];
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_valid_vec;

    assign w_elem  = s_axis_tdata[ELEM_W-1:0];
    assign w_qsum  = s_axis_tdata[ELEM_W +: QSUM_W];
    assign w_cmd   = s_axis_tuser;
    assign w_value = VALUE_BITS'(w_elem[VIN_W-1:0]);
    assign w_limit = CMP_W'(w_qsum);

    assign s_axis_tready = !r_q1;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;
    assign w_full        = w_link[CAPACITY].valid;

    // command decode
    always_comb begin
        w_load  = 1'b0;
        w_clear = 1'b0;
        w_query = 1'b0;
        if (w_in_fire) begin
            unique case (w_cmd)
                CMD_LOAD:  w_load  = (w_value != '0) && !w_full;
                CMD_QUERY: w_query = 1'b1;
                CMD_CLEAR: w_clear = 1'b1;
                default:   ;  // unused code, no effect
            endcase
        end
    end

    // seed: always valid and never shifting, so the first cell takes the new value
    assign w_link[0] = '{valid: 1'b1, shift: 1'b0};
    assign w_vals[0] = '0;
    assign w_sums[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spcu_cell #(
            .VALUE_BITS (VALUE_BITS),
            .SUM_W      (SUM_W),
            .CMP_W      (CMP_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (w_load),
            .i_clear      (w_clear),
            .i_query      (w_query),
            .i_value      (w_value),
            .i_limit      (w_limit),
            .i_left       (w_link[g]),
            .i_left_value (w_vals[g]),
            .i_left_sum   (w_sums[g]),
            .o_link       (w_link[g+1]),
            .o_value      (w_vals[g+1]),
            .o_sum        (w_sums[g+1]),
            .o_hit        (w_hit[g])
        );
        assign w_valid_vec[g] = w_link[g+1].valid;
    end

    spcu_count_enc #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_enc (
        .i_hit (w_hit),
        .o_len (w_len)
    );

    // second query stage moves into the output register once it is free
    assign w_advance = r_q1 && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_q1 = r_q1;
        if (w_query) begin
            n_q1 = 1'b1;
        end else if (w_advance) begin
            n_q1 = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_q1        <= n_q1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_len <= w_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TD_W'(r_len);

    // stored entries always fill the chain from the left
    a_valid_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
        else $error("valid cells not contiguous from the left");

    // sums rise strictly, so captured hits must form a thermometer
    a_hit_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q1 |-> (((w_hit >> 1) & ~w_hit) == '0))
        else $error("hit flags not a thermometer");

    // a result appears only after a query was captured
    a_out_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_q1))
        else $error("result without a query");

    // a load never grows the chain by more than one cell
    a_grow_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> ($countones(w_valid_vec) <= $countones($past(w_valid_vec)) + 1))
        else $error("load added more than one entry");

endmodule

`default_nettype wire

[rtl/core/spcu_cell.sv]
// one storage cell of the sorted chain: a value, its running sum and a valid bit
// depends on spcu_pkg
`default_nettype none

module spcu_cell
    import spcu_pkg::*;
#(
    parameter int VALUE_BITS = 20,
    parameter int SUM_W      = 26,
    parameter int CMP_W      = 26
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic                  i_clear,
    input  wire logic                  i_query,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [CMP_W-1:0]      i_limit,
    input  wire t_link                 i_left,
    input  wire logic [VALUE_BITS-1:0] i_left_value,
    input  wire logic [SUM_W-1:0]      i_left_sum,
    output t_link                      o_link,
    output logic [VALUE_BITS-1:0]      o_value,
    output logic [SUM_W-1:0]           o_sum,
    output logic                       o_hit
);

    logic                  r_valid;
    logic                  n_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_hit;
    logic                  w_shift;

    // stays put only if it holds a value no greater than the new one
    assign w_shift = !(r_valid && (r_value <= i_value));

    always_comb begin
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (i_load) begin
            n_valid = r_valid | i_left.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: from this cell on, every sum is the left sum plus the new value
    always_ff @(posedge i_clk) begin
        if (i_load && w_shift) begin
            r_value <= i_left.shift ? i_left_value : i_value;
            r_sum   <= i_left_sum + SUM_W'(i_value);
        end
        if (i_query) begin
            r_hit <= r_valid && (CMP_W'(r_sum) <= i_limit);
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.shift = w_shift;
    assign o_value      = r_value;
    assign o_sum        = r_sum;
    assign o_hit        = r_hit;

endmodule

`default_nettype wire

[rtl/core/spcu_count_enc.sv]
// thermometer-to-count encoder over the registered hit flags of the chain
// depends on spcu_pkg
`default_nettype none

module spcu_count_enc
    import spcu_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  wire logic [CAPACITY-1:0] i_hit,
    output logic [LEN_W-1:0]         o_len
);

    logic [CNT_W-1:0] w_cnt;

    // hits form a thermometer, so the count is one past the last set flag
    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_hit[i] && ((i == CAPACITY - 1) || !i_hit[(i + 1) % CAPACITY])) begin
                w_cnt = w_cnt | CNT_W'(i + 1);
            end
        end
    end

    assign o_len = LEN_W'(w_cnt);

endmodule

`default_nettype wire
